FILE: rtl/ghsm_pkg.sv
// ----------------------------------------------------------------------------
// ghsm_pkg
// Shared widths, operation and status codes and controller states for the
// generational handle slot map.
// ----------------------------------------------------------------------------
package ghsm_pkg;

  localparam int OP_W           = 2;
  localparam int STATUS_W       = 2;
  localparam int SLOT_W         = 10;
  localparam int GEN_W          = 32;
  localparam int DENSE_W        = 10;

  localparam int NUM_SLOTS_DEF  = 1024;
  localparam int GEN_BITS_DEF   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_RELINK = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

endpackage

FILE: rtl/ghsm_ram.sv
// ----------------------------------------------------------------------------
// ghsm_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port that holds its data until the next read.
// ----------------------------------------------------------------------------
module ghsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/generational_handle_slot_map.sv
// ----------------------------------------------------------------------------
// generational_handle_slot_map
// Fixed-capacity handle table: alloc, free, lookup and relink of slots that
// carry a generation count and a dense index.
// ----------------------------------------------------------------------------
// Usage: one request beat on the input channel (op, slot_ref,
// handle_generation, dense_index under in_valid/in_ready) yields exactly one
// result beat on the output channel (status, out_slot, out_generation,
// out_dense under out_valid/out_ready), in request order.
// Sequence: free, lookup, relink and an alloc that takes a fresh slot or
// reports full go from IDLE straight to EXEC; an alloc that pops a recycled
// slot passes through POP first, since the stack read precedes the slot
// read. A new request is taken once the previous one has finished its
// write-back, so requests never overlap; their pace is set by the
// read-then-write of the slot record memory.
// Reset: stack depth and high-water mark clear; no clearing pass is run,
// slots at or above the high-water mark read as generation zero.
// Stall: a waiting result sits in the output register while the next
// request is read; its write-back waits until out_ready frees the register.
// ----------------------------------------------------------------------------
module generational_handle_slot_map #(
  parameter int NUM_SLOTS = ghsm_pkg::NUM_SLOTS_DEF,
  parameter int GEN_BITS  = ghsm_pkg::GEN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ghsm_pkg::OP_W-1:0]     op,
  input  logic [ghsm_pkg::SLOT_W-1:0]   slot_ref,
  input  logic [ghsm_pkg::GEN_W-1:0]    handle_generation,
  input  logic [ghsm_pkg::DENSE_W-1:0]  dense_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ghsm_pkg::STATUS_W-1:0] status,
  output logic [ghsm_pkg::SLOT_W-1:0]   out_slot,
  output logic [ghsm_pkg::GEN_W-1:0]    out_generation,
  output logic [ghsm_pkg::DENSE_W-1:0]  out_dense
);
  import ghsm_pkg::*;

  localparam int AW    = $clog2(NUM_SLOTS);
  localparam int CW    = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int REC_W = GEN_BITS + 1 + DENSE_W;
  localparam logic [AW:0] NUM_SLOTS_C = (AW+1)'(NUM_SLOTS);

  state_t                state;
  logic [AW:0]           free_depth;
  logic [AW:0]           high_water;

  op_t                   op_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [GEN_W-1:0]      hgen_r;
  logic [DENSE_W-1:0]    dense_r;
  logic [AW-1:0]         cur_slot;
  logic                  fresh_r;
  logic                  full_r;
  logic                  range_r;

  logic                  accept;
  logic                  go;
  logic                  commit;
  logic [CW-1:0]         slot_ext;
  logic [CW-1:0]         cur_ext;
  logic [AW-1:0]         slot_addr_in;
  logic                  in_range;
  logic [AW:0]           depth_m1;

  logic                  rec_re;
  logic [AW-1:0]         rec_raddr;
  logic                  rec_we;
  logic [REC_W-1:0]      rec_wdata;
  logic [REC_W-1:0]      rec_rdata;
  logic                  stk_re;
  logic                  stk_we;
  logic [AW-1:0]         stk_rdata;

  logic [GEN_BITS-1:0]   rd_gen;
  logic                  rd_empty;
  logic [DENSE_W-1:0]    rd_dense;
  logic [GEN_BITS-1:0]   gen_cur;
  logic [GEN_BITS-1:0]   gen_inc;

  status_t               res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [GEN_BITS-1:0]   res_gen;
  logic [DENSE_W-1:0]    res_dense;
  logic                  depth_inc;
  logic                  depth_dec;
  logic                  hw_inc;

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign go           = !out_valid || out_ready;
  assign commit       = (state == S_EXEC) && go;
  assign slot_ext     = CW'(slot_ref);
  assign slot_addr_in = slot_ext[AW-1:0];
  assign in_range     = (CW+1)'(slot_ref) < (CW+1)'(high_water);
  assign depth_m1     = free_depth - 1'b1;
  assign cur_ext      = CW'(cur_slot);

  assign stk_re    = accept && (op_t'(op) == OP_ALLOC) && (free_depth != '0);
  assign rec_re    = (accept && (op_t'(op) != OP_ALLOC) && in_range) || (state == S_POP);
  assign rec_raddr = (state == S_POP) ? stk_rdata : slot_addr_in;

  assign rd_gen   = rec_rdata[REC_W-1 -: GEN_BITS];
  assign rd_empty = rec_rdata[DENSE_W];
  assign rd_dense = rec_rdata[DENSE_W-1:0];
  assign gen_cur  = fresh_r ? '0 : rd_gen;
  assign gen_inc  = rd_gen + 1'b1;

  always_comb begin
    res_status = ST_OK;
    res_slot   = slot_r;
    res_gen    = rd_gen;
    res_dense  = '0;
    rec_we     = 1'b0;
    rec_wdata  = {rd_gen, 1'b0, dense_r};
    stk_we     = 1'b0;
    depth_inc  = 1'b0;
    depth_dec  = 1'b0;
    hw_inc     = 1'b0;
    if (op_r == OP_ALLOC) begin
      if (full_r) begin
        res_status = ST_FULL;
        res_gen    = '0;
      end else begin
        res_slot  = cur_ext[SLOT_W-1:0];
        res_gen   = gen_cur;
        rec_we    = 1'b1;
        rec_wdata = {gen_cur, 1'b0, dense_r};
        hw_inc    = fresh_r;
        depth_dec = !fresh_r;
      end
    end else if (range_r) begin
      res_status = ST_RANGE;
      res_gen    = '0;
    end else begin
      case (op_r)
        OP_FREE: begin
          if (rd_empty || (free_depth >= NUM_SLOTS_C)) begin
            res_status = ST_STALE;
          end else begin
            res_gen   = gen_inc;
            rec_we    = 1'b1;
            rec_wdata = {gen_inc, 1'b1, {DENSE_W{1'b0}}};
            stk_we    = 1'b1;
            depth_inc = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (rd_empty || (GEN_W'(rd_gen) != hgen_r)) begin
            res_status = ST_STALE;
          end else begin
            res_dense = rd_dense;
          end
        end
        OP_RELINK: begin
          if (rd_empty) begin
            res_status = ST_STALE;
          end else begin
            rec_we = 1'b1;
          end
        end
        default: begin
          res_status = ST_STALE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      free_depth <= '0;
      high_water <= '0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (commit && depth_inc) begin
        free_depth <= free_depth + 1'b1;
      end else if (commit && depth_dec) begin
        free_depth <= depth_m1;
      end
      if (commit && hw_inc) begin
        high_water <= high_water + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= stk_re ? S_POP : S_EXEC;
          end
        end
        S_POP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(op);
      slot_r  <= slot_ref;
      hgen_r  <= handle_generation;
      dense_r <= dense_index;
      range_r <= !in_range;
      fresh_r <= (free_depth == '0) && (high_water < NUM_SLOTS_C);
      full_r  <= (free_depth == '0) && (high_water >= NUM_SLOTS_C);
      if (op_t'(op) == OP_ALLOC) begin
        cur_slot <= high_water[AW-1:0];
      end else begin
        cur_slot <= slot_addr_in;
      end
    end else if (state == S_POP) begin
      cur_slot <= stk_rdata;
    end
    if (commit) begin
      status         <= res_status;
      out_slot       <= res_slot;
      out_generation <= GEN_W'(res_gen);
      out_dense      <= res_dense;
    end
  end

  ghsm_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (commit && rec_we),
    .waddr (cur_slot),
    .wdata (rec_wdata),
    .re    (rec_re),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  ghsm_ram #(
    .WIDTH (AW),
    .DEPTH (NUM_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (commit && stk_we),
    .waddr (free_depth[AW-1:0]),
    .wdata (cur_slot),
    .re    (stk_re),
    .raddr (depth_m1[AW-1:0]),
    .rdata (stk_rdata)
  );

`ifndef SYNTH
  a_depth_le_hw: assert property (@(posedge clk) disable iff (rst)
    free_depth <= high_water)
    else $error("free stack deeper than high-water mark");

  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    high_water <= NUM_SLOTS_C)
    else $error("high-water mark beyond capacity");

  a_pop_path: assert property (@(posedge clk) disable iff (rst)
    stk_re |=> (state == S_POP))
    else $error("recycled alloc skipped the stack read");

  a_pop_to_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (state == S_EXEC))
    else $error("stack read not followed by execute");

  a_free_push: assert property (@(posedge clk) disable iff (rst)
    (commit && stk_we) |=> (free_depth == $past(free_depth) + 1'b1))
    else $error("free did not push the stack");
`endif

endmodule
